// ===== hdl/keyed_count_table_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef KEYED_COUNT_TABLE_MACROS_SVH
`define KEYED_COUNT_TABLE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define KCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define KCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/kct_pkg.sv =====
`timescale 1ns / 1ps

package kct_pkg;

  localparam int ENTRIES_DEF   = 32;
  localparam int KEY_BYTES_DEF = 8;

  localparam int KEY_IN_W = 64;
  localparam int CNT_W    = 8;
  localparam int STAT_W   = 3;
  localparam int USED_W   = 6;

  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_ADD_NEW  = 3'd0,
    STAT_ADD_OLD  = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_MISSING  = 3'd4,
    STAT_TOO_MANY = 3'd5,
    STAT_REMOVED  = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE_RD,
    S_MOVE_WR,
    S_RESP
  } state_e;

endpackage

// ===== hdl/keyed_count_table.sv =====
// A request is accepted in idle and, unless an add finds the table full or a remove
// finds it empty, scans the occupied entries until the key is found (all of them
// when absent); a deletion that frees a slot other than the last moves the last entry in.
// The input stalls from acceptance until the result is loaded into the output registers.
// Reset clears the occupancy count and the control state; the stores are not cleared.
`timescale 1ns / 1ps
`include "keyed_count_table_macros.svh"

module keyed_count_table #(
  parameter int ENTRIES   = kct_pkg::ENTRIES_DEF,
  parameter int KEY_BYTES = kct_pkg::KEY_BYTES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      action_i,
  input  logic [kct_pkg::KEY_IN_W-1:0] item_key_i,
  input  logic [kct_pkg::CNT_W-1:0] amount_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [kct_pkg::STAT_W-1:0] status_o,
  output logic                      entry_deleted_o,
  output logic [kct_pkg::CNT_W-1:0] new_count_o,
  output logic [kct_pkg::USED_W-1:0] entries_used_o
);
  import kct_pkg::*;

  localparam int KEY_W = KEY_BYTES * 8;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int OCC_W = $clog2(ENTRIES + 1);

  state_e            state_q, state_d;
  logic [OCC_W-1:0]  occ_q, occ_d;
  logic              act_q, act_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [CNT_W-1:0]  amt_q, amt_d;
  logic [OCC_W-1:0]  ia_q, ia_d;
  logic              cv_q, cv_d;
  logic [IDX_W-1:0]  ci_q, ci_d;
  logic [IDX_W-1:0]  pos_q, pos_d;
  status_e           rstat_q, rstat_d;
  logic              rdel_q, rdel_d;
  logic [CNT_W-1:0]  rcnt_q, rcnt_d;

  logic              out_vld_q, out_vld_d;
  status_e           ostat_q, ostat_d;
  logic              odel_q, odel_d;
  logic [CNT_W-1:0]  ocnt_q, ocnt_d;
  logic [USED_W-1:0] oused_q, oused_d;

  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  logic [KEY_W-1:0]  mem_wkey, rd_key;
  logic [CNT_W-1:0]  mem_wcnt, rd_cnt;

  logic              hit;
  logic [CNT_W-1:0]  sum_add, diff_rem;
  logic              out_free;

  kct_store #(
    .DEPTH (ENTRIES),
    .KEY_W (KEY_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wkey_i  (mem_wkey),
    .wcnt_i  (mem_wcnt),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rkey_o  (rd_key),
    .rcnt_o  (rd_cnt)
  );

  assign hit      = cv_q && (rd_key == key_q);
  assign sum_add  = rd_cnt + amt_q;
  assign diff_rem = rd_cnt - amt_q;
  assign out_free = !out_vld_q || !out_stall_i;

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      occ_q     <= '0;
      cv_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      occ_q     <= occ_d;
      cv_q      <= cv_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    key_q   <= key_d;
    amt_q   <= amt_d;
    ia_q    <= ia_d;
    ci_q    <= ci_d;
    pos_q   <= pos_d;
    rstat_q <= rstat_d;
    rdel_q  <= rdel_d;
    rcnt_q  <= rcnt_d;
    ostat_q <= ostat_d;
    odel_q  <= odel_d;
    ocnt_q  <= ocnt_d;
    oused_q <= oused_d;
  end

  always_comb begin
    state_d   = state_q;
    occ_d     = occ_q;
    act_d     = act_q;
    key_d     = key_q;
    amt_d     = amt_q;
    ia_d      = ia_q;
    cv_d      = 1'b0;
    ci_d      = ci_q;
    pos_d     = pos_q;
    rstat_d   = rstat_q;
    rdel_d    = rdel_q;
    rcnt_d    = rcnt_q;
    out_vld_d = out_vld_q && out_stall_i;
    ostat_d   = ostat_q;
    odel_d    = odel_q;
    ocnt_d    = ocnt_q;
    oused_d   = oused_q;
    mem_we    = 1'b0;
    mem_waddr = pos_q;
    mem_wkey  = key_q;
    mem_wcnt  = amt_q;
    mem_re    = 1'b0;
    mem_raddr = ia_q[IDX_W-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d   = action_i;
          key_d   = item_key_i[KEY_W-1:0];
          amt_d   = amount_i;
          ia_d    = '0;
          rdel_d  = 1'b0;
          rcnt_d  = '0;
          if (action_i == ACT_ADD && occ_q == OCC_W'(ENTRIES)) begin
            rstat_d = STAT_FULL;
            state_d = S_RESP;
          end else if (action_i == ACT_REMOVE && occ_q == '0) begin
            rstat_d = STAT_EMPTY;
            state_d = S_RESP;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          if (act_q == ACT_ADD) begin
            mem_we    = 1'b1;
            mem_waddr = ci_q;
            mem_wcnt  = sum_add;
            rstat_d   = STAT_ADD_OLD;
            rcnt_d    = sum_add;
            state_d   = S_RESP;
          end else if (amt_q > rd_cnt) begin
            rstat_d = STAT_TOO_MANY;
            state_d = S_RESP;
          end else if (diff_rem != '0) begin
            mem_we    = 1'b1;
            mem_waddr = ci_q;
            mem_wcnt  = diff_rem;
            rstat_d   = STAT_REMOVED;
            rcnt_d    = diff_rem;
            state_d   = S_RESP;
          end else if (OCC_W'(ci_q) == occ_q - OCC_W'(1)) begin
            occ_d   = occ_q - OCC_W'(1);
            rstat_d = STAT_REMOVED;
            rdel_d  = 1'b1;
            state_d = S_RESP;
          end else begin
            pos_d   = ci_q;
            state_d = S_MOVE_RD;
          end
        end else if (ia_q < occ_q) begin
          mem_re    = 1'b1;
          mem_raddr = ia_q[IDX_W-1:0];
          ia_d      = ia_q + OCC_W'(1);
          cv_d      = 1'b1;
          ci_d      = ia_q[IDX_W-1:0];
        end else if (act_q == ACT_ADD) begin
          mem_we    = 1'b1;
          mem_waddr = occ_q[IDX_W-1:0];
          mem_wkey  = key_q;
          mem_wcnt  = amt_q;
          occ_d     = occ_q + OCC_W'(1);
          rstat_d   = STAT_ADD_NEW;
          rcnt_d    = amt_q;
          state_d   = S_RESP;
        end else begin
          rstat_d = STAT_MISSING;
          state_d = S_RESP;
        end
      end

      S_MOVE_RD: begin
        mem_re    = 1'b1;
        mem_raddr = occ_q[IDX_W-1:0] - IDX_W'(1);
        state_d   = S_MOVE_WR;
      end

      S_MOVE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        mem_wkey  = rd_key;
        mem_wcnt  = rd_cnt;
        occ_d     = occ_q - OCC_W'(1);
        rstat_d   = STAT_REMOVED;
        rdel_d    = 1'b1;
        state_d   = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          ostat_d   = rstat_q;
          odel_d    = rdel_q;
          ocnt_d    = rcnt_q;
          oused_d   = USED_W'(occ_q);
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o     = out_vld_q;
  assign status_o        = ostat_q;
  assign entry_deleted_o = odel_q;
  assign new_count_o     = ocnt_q;
  assign entries_used_o  = oused_q;

  `KCT_ASSERT_NOW(a_occ_bound, 1'b1, occ_q <= OCC_W'(ENTRIES), "occupancy above table size")
  `KCT_ASSERT_NEXT(a_occ_step, 1'b1, (occ_q == $past(occ_q)) || (occ_q == $past(occ_q) + OCC_W'(1)) || (occ_q == $past(occ_q) - OCC_W'(1)), "occupancy moved by more than one")
  `KCT_ASSERT_NOW(a_idle_no_write, state_q == S_IDLE, !mem_we, "store written while idle")
  `KCT_ASSERT_NOW(a_del_zero, out_vld_q && odel_q, ocnt_q == '0 && ostat_q == STAT_REMOVED, "deletion with nonzero count")

endmodule

// ===== hdl/kct_store.sv =====
`timescale 1ns / 1ps

module kct_store #(
  parameter int DEPTH = 32,
  parameter int KEY_W = 64,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [IDX_W-1:0]        waddr_i,
  input  logic [KEY_W-1:0]        wkey_i,
  input  logic [kct_pkg::CNT_W-1:0] wcnt_i,
  input  logic                    re_i,
  input  logic [IDX_W-1:0]        raddr_i,
  output logic [KEY_W-1:0]        rkey_o,
  output logic [kct_pkg::CNT_W-1:0] rcnt_o
);
  import kct_pkg::*;

  logic [KEY_W-1:0] key_mem [DEPTH];
  logic [CNT_W-1:0] cnt_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[waddr_i] <= wkey_i;
      cnt_mem[waddr_i] <= wcnt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rkey_o <= key_mem[raddr_i];
      rcnt_o <= cnt_mem[raddr_i];
    end
  end

endmodule

// ===== dv/keyed_count_table_checker.sv =====
`timescale 1ns / 1ps

module keyed_count_table_checker #(
  parameter int ENTRIES   = kct_pkg::ENTRIES_DEF,
  parameter int KEY_BYTES = kct_pkg::KEY_BYTES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic                         action_i,
  input  logic [kct_pkg::KEY_IN_W-1:0] item_key_i,
  input  logic [kct_pkg::CNT_W-1:0]    amount_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [kct_pkg::STAT_W-1:0]   status_i,
  input  logic                         entry_deleted_i,
  input  logic [kct_pkg::CNT_W-1:0]    new_count_i,
  input  logic [kct_pkg::USED_W-1:0]   entries_used_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import kct_pkg::*;

  typedef struct packed {
    status_e             status;
    logic                deleted;
    logic [CNT_W-1:0]    count;
    logic [USED_W-1:0]   used;
  } request_outcome_t;

  localparam logic [KEY_IN_W-1:0] KEY_MASK =
    (KEY_BYTES >= 8) ? {KEY_IN_W{1'b1}} : ((64'd1 << (8 * KEY_BYTES)) - 64'd1);

  logic [KEY_IN_W-1:0] table_key   [ENTRIES];
  logic [CNT_W-1:0]    table_count [ENTRIES];
  int                  occupied_entries = 0;
  request_outcome_t    expected_outcomes [$];
  int                  mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic request_outcome_t apply_request(logic act, logic [KEY_IN_W-1:0] key_in,
                                                     logic [CNT_W-1:0] amt);
    request_outcome_t    r;
    logic [KEY_IN_W-1:0] key;
    int                  pos;
    r.status  = STAT_ADD_NEW;
    r.deleted = 1'b0;
    r.count   = '0;
    key = key_in & KEY_MASK;
    pos = -1;
    for (int i = 0; i < occupied_entries; i++) begin
      if (pos < 0 && table_key[i] == key) pos = i;
    end
    if (act == ACT_ADD) begin
      if (occupied_entries >= ENTRIES) begin
        r.status = STAT_FULL;
      end else if (pos >= 0) begin
        table_count[pos] = table_count[pos] + amt;
        r.count  = table_count[pos];
        r.status = STAT_ADD_OLD;
      end else begin
        table_key[occupied_entries]   = key;
        table_count[occupied_entries] = amt;
        occupied_entries++;
        r.count  = amt;
        r.status = STAT_ADD_NEW;
      end
    end else if (occupied_entries == 0) begin
      r.status = STAT_EMPTY;
    end else if (pos < 0) begin
      r.status = STAT_MISSING;
    end else if (amt > table_count[pos]) begin
      r.status = STAT_TOO_MANY;
    end else begin
      table_count[pos] = table_count[pos] - amt;
      r.count  = table_count[pos];
      r.status = STAT_REMOVED;
      if (r.count == '0) begin
        // drop the entry and pack the later ones down
        for (int j = pos; j < occupied_entries - 1; j++) begin
          table_key[j]   = table_key[j + 1];
          table_count[j] = table_count[j + 1];
        end
        occupied_entries--;
        r.deleted = 1'b1;
      end
    end
    r.used = USED_W'(occupied_entries);
    return r;
  endfunction

  function automatic int check_field(string field, int expected_val, int actual_val);
    if (expected_val != actual_val) begin
      $error("%s: expected %0d, got %0d", field, expected_val, actual_val);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i) begin
    request_outcome_t predicted;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_outcomes.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          predicted = expected_outcomes.pop_front();
          mismatches += check_field("status", predicted.status, status_i);
          mismatches += check_field("entry_deleted", predicted.deleted, entry_deleted_i);
          mismatches += check_field("new_count", predicted.count, new_count_i);
          mismatches += check_field("entries_used", predicted.used, entries_used_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_outcomes.push_back(apply_request(action_i, item_key_i, amount_i));
      end
      pending_o <= expected_outcomes.size();
    end
  end

endmodule

// ===== dv/keyed_count_table_tb.sv =====
`timescale 1ns / 1ps

module keyed_count_table_tb;
  import kct_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int KEY_POOL    = 48;
  localparam int PHASE_ITEMS = 300;
  localparam int SENDER_IDLE [4] = '{0, 64, 0, 37};
  localparam int RECV_STALL  [4] = '{0, 0, 64, 37};

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                action_i    = ACT_ADD;
  logic [KEY_IN_W-1:0] item_key_i  = '0;
  logic [CNT_W-1:0]    amount_i    = '0;
  logic                out_stall_i = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic [STAT_W-1:0]   status_o;
  logic                entry_deleted_o;
  logic [CNT_W-1:0]    new_count_o;
  logic [USED_W-1:0]   entries_used_o;

  int                  fail_count;
  int                  pending_count;
  int                  idle_pct    = 0;
  int                  stall_pct   = 0;
  int                  cycle_count = 0;
  logic [KEY_IN_W-1:0] key_pool [KEY_POOL];

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  keyed_count_table dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .action_i,
    .item_key_i,
    .amount_i,
    .out_valid_o,
    .out_stall_i,
    .status_o,
    .entry_deleted_o,
    .new_count_o,
    .entries_used_o
  );

  keyed_count_table_checker checker_i (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_i      (in_stall_o),
    .action_i,
    .item_key_i,
    .amount_i,
    .out_valid_i     (out_valid_o),
    .out_stall_i,
    .status_i        (status_o),
    .entry_deleted_i (entry_deleted_o),
    .new_count_i     (new_count_o),
    .entries_used_i  (entries_used_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending_count)
  );

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_request(logic act, logic [KEY_IN_W-1:0] key, logic [CNT_W-1:0] amt);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    item_key_i <= key;
    amount_i   <= amt;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_requests();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
  endtask

  initial begin
    logic                act;
    logic [KEY_IN_W-1:0] key;
    logic [CNT_W-1:0]    amt;
    int                  add_pct;
    for (int i = 0; i < KEY_POOL; i++) begin
      // shorter names: zero padded in the upper bytes
      key_pool[i] = {$urandom, $urandom} >> (8 * (i % 8));
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(ACT_REMOVE, 64'h0, 8'd5);
    send_request(ACT_ADD, 64'h0, 8'd0);
    send_request(ACT_ADD, 64'h0, 8'd0);
    send_request(ACT_ADD, {KEY_IN_W{1'b1}}, 8'd255);
    send_request(ACT_ADD, {KEY_IN_W{1'b1}}, 8'd1);
    send_request(ACT_REMOVE, {KEY_IN_W{1'b1}}, 8'd0);
    send_request(ACT_REMOVE, {KEY_IN_W{1'b1}}, 8'd0);
    send_request(ACT_ADD, 64'h0000_0000_0000_0041, 8'd10);
    send_request(ACT_ADD, 64'h4100_0000_0000_0041, 8'd7);
    send_request(ACT_REMOVE, 64'h0000_0000_0000_0041, 8'd11);
    send_request(ACT_REMOVE, 64'h0000_0000_0000_0041, 8'd4);
    send_request(ACT_REMOVE, 64'h4100_0000_0000_0041, 8'd7);
    send_request(ACT_REMOVE, 64'h0000_0000_0000_0041, 8'd6);
    send_request(ACT_REMOVE, 64'h0, 8'd0);
    send_request(ACT_REMOVE, 64'h5555_5555_5555_5555, 8'd0);
    send_request(ACT_ADD, 64'haaaa_aaaa_aaaa_aaaa, 8'd128);
    send_request(ACT_ADD, 64'h5555_5555_5555_5555, 8'd255);
    send_request(ACT_REMOVE, 64'haaaa_aaaa_aaaa_aaaa, 8'd255);
    // hold off until the table has answered everything
    drain_requests();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = SENDER_IDLE[p];
      stall_pct = RECV_STALL[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // alternate fill-heavy and drain-heavy stretches
        add_pct = ((n / 60) % 2 == 0) ? 75 : 35;
        act = ($urandom_range(99) < add_pct) ? ACT_ADD : ACT_REMOVE;
        key = ($urandom_range(19) == 0) ? {$urandom, $urandom}
                                         : key_pool[$urandom_range(KEY_POOL - 1)];
        amt = ($urandom_range(3) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(3));
        send_request(act, key, amt);
      end
      drain_requests();
    end

    stall_pct = 0;
    repeat (64) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
